// ===== rtl/core/lmt_pkg.sv =====
package lmt_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // mode durations in cpu cycles
    localparam logic [7:0] HBLANK_CYCLES = 8'd204;
    localparam logic [7:0] OAM_CYCLES    = 8'd80;
    localparam logic [7:0] VRAM_CYCLES   = 8'd172;

    // line limits
    localparam logic [7:0] VBLANK_LINE     = 8'd144;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;

    // register addresses
    localparam logic [15:0] ADDR_LCDC = 16'hff40;
    localparam logic [15:0] ADDR_STAT = 16'hff41;
    localparam logic [15:0] ADDR_SCY  = 16'hff42;
    localparam logic [15:0] ADDR_SCX  = 16'hff43;
    localparam logic [15:0] ADDR_LY   = 16'hff44;
    localparam logic [15:0] ADDR_LYC  = 16'hff45;
    localparam logic [15:0] ADDR_DMA  = 16'hff46;
    localparam logic [15:0] ADDR_BGP  = 16'hff47;
    localparam logic [15:0] ADDR_OBP0 = 16'hff48;
    localparam logic [15:0] ADDR_OBP1 = 16'hff49;
    localparam logic [15:0] ADDR_WY   = 16'hff4a;
    localparam logic [15:0] ADDR_WX   = 16'hff4b;

    // display mode, as shown in the stat mode field
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_VRAM   = 2'd3
    } mode_t;

    // decoded register select
    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_LCDC,
        SEL_STAT,
        SEL_SCY,
        SEL_SCX,
        SEL_LY,
        SEL_LYC,
        SEL_DMA,
        SEL_BGP,
        SEL_OBP0,
        SEL_OBP1,
        SEL_WY,
        SEL_WX
    } reg_sel_t;

    // input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  elapsed_cycles;
    } lmt_in_t;

    // result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       claimed;
        logic       vblank_request;
        logic       stat_request;
        logic [1:0] current_mode;
        logic [7:0] current_line;
    } lmt_out_t;

endpackage

// ===== rtl/core/lmt_core.sv =====
module lmt_core
    import lmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  lmt_in_t  item,
    output lmt_out_t result
);

    // register state
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [5:0]  stat_hi_reg, stat_hi_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  scy_reg, scy_next;
    logic [7:0]  scx_reg, scx_next;
    logic [7:0]  ly_reg, ly_next;
    logic [7:0]  lyc_reg, lyc_next;
    logic [7:0]  bgp_reg, bgp_next;
    logic [7:0]  obp0_reg, obp0_next;
    logic [7:0]  obp1_reg, obp1_next;
    logic [7:0]  wy_reg, wy_next;
    logic [7:0]  wx_reg, wx_next;
    logic [15:0] accum_reg, accum_next;

    logic        is_tick;
    logic        is_read;
    logic        is_write;
    logic        lcd_on;
    logic [16:0] sum;
    logic [15:0] sat;
    logic [7:0]  need;
    logic        due;
    logic [7:0]  line_inc;
    logic [7:0]  line_wrap;
    logic        vbl_hit;
    logic        coincide;
    logic [1:0]  mode_show;
    reg_sel_t    sel;

    // status enable bits (stat_hi_reg[i] holds stat bit i+2)
    logic en_hbl, en_vbl, en_oam, en_lyc;
    assign en_hbl = stat_hi_reg[1];
    assign en_vbl = stat_hi_reg[2];
    assign en_oam = stat_hi_reg[3];
    assign en_lyc = stat_hi_reg[4];

    // item kind
    assign is_tick  = (item.kind == KIND_TICK);
    assign is_read  = (item.kind == KIND_READ);
    assign is_write = (item.kind == KIND_WRITE);
    assign lcd_on   = ctrl_reg[7];

    // saturating accumulator sum
    assign sum = {1'b0, accum_reg} + {9'd0, item.elapsed_cycles};
    assign sat = sum[16] ? 16'hffff : sum[15:0];

    // duration of the current mode
    always_comb
    begin
        case (mode_reg)
            MODE_HBLANK: need = HBLANK_CYCLES;
            MODE_OAM:    need = OAM_CYCLES;
            MODE_VRAM:   need = VRAM_CYCLES;
            default:     need = 8'd0;
        endcase
    end

    assign due = (mode_reg != MODE_VBLANK) && (sat >= {8'd0, need});

    // line advance on hblank to oam
    assign line_inc  = ly_reg + 8'd1;
    assign line_wrap = (line_inc >= LINES_PER_FRAME) ? 8'd0 : line_inc;
    assign vbl_hit   = (line_inc == VBLANK_LINE);

    // stat read view
    assign coincide  = (ly_reg == lyc_reg);
    assign mode_show = (ly_reg >= VBLANK_LINE) ? MODE_VBLANK : mode_reg;

    // address decode
    always_comb
    begin
        unique case (item.address)
            ADDR_LCDC: sel = SEL_LCDC;
            ADDR_STAT: sel = SEL_STAT;
            ADDR_SCY:  sel = SEL_SCY;
            ADDR_SCX:  sel = SEL_SCX;
            ADDR_LY:   sel = SEL_LY;
            ADDR_LYC:  sel = SEL_LYC;
            ADDR_DMA:  sel = SEL_DMA;
            ADDR_BGP:  sel = SEL_BGP;
            ADDR_OBP0: sel = SEL_OBP0;
            ADDR_OBP1: sel = SEL_OBP1;
            ADDR_WY:   sel = SEL_WY;
            ADDR_WX:   sel = SEL_WX;
            default:   sel = SEL_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        ctrl_next    = ctrl_reg;
        stat_hi_next = stat_hi_reg;
        mode_next    = mode_reg;
        scy_next     = scy_reg;
        scx_next     = scx_reg;
        ly_next      = ly_reg;
        lyc_next     = lyc_reg;
        bgp_next     = bgp_reg;
        obp0_next    = obp0_reg;
        obp1_next    = obp1_reg;
        wy_next      = wy_reg;
        wx_next      = wx_reg;
        accum_next   = accum_reg;
        if (step)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    if (!lcd_on)
                    begin
                        ly_next   = 8'd0;
                        mode_next = MODE_HBLANK;
                    end
                    else
                    begin
                        accum_next = sat;
                        if (due)
                        begin
                            accum_next = sat - {8'd0, need};
                            unique case (mode_reg)
                                MODE_HBLANK:
                                begin
                                    mode_next = MODE_OAM;
                                    ly_next   = line_wrap;
                                end
                                MODE_OAM:  mode_next = MODE_VRAM;
                                MODE_VRAM: mode_next = MODE_HBLANK;
                                default:   mode_next = mode_reg;
                            endcase
                        end
                    end
                end
                KIND_READ:
                begin
                    if (sel == SEL_STAT)
                    begin
                        stat_hi_next[0] = coincide;
                    end
                end
                KIND_WRITE:
                begin
                    unique case (sel)
                        SEL_LCDC:
                        begin
                            if (!ctrl_reg[7] && item.write_data[7])
                            begin
                                ly_next    = 8'd0;
                                accum_next = 16'd0;
                                mode_next  = MODE_OAM;
                            end
                            ctrl_next = item.write_data;
                        end
                        SEL_STAT: stat_hi_next = item.write_data[7:2];
                        SEL_SCY:  scy_next     = item.write_data;
                        SEL_SCX:  scx_next     = item.write_data;
                        SEL_LYC:  lyc_next     = item.write_data;
                        SEL_BGP:  bgp_next     = item.write_data;
                        SEL_OBP0: obp0_next    = item.write_data;
                        SEL_OBP1: obp1_next    = item.write_data;
                        SEL_WY:   wy_next      = item.write_data;
                        SEL_WX:   wx_next      = item.write_data;
                        default:  ctrl_next    = ctrl_reg;
                    endcase
                end
                default:
                begin
                    ctrl_next = ctrl_reg;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        result = '0;
        if (is_read)
        begin
            result.claimed = (sel != SEL_NONE) && (sel != SEL_DMA);
            case (sel)
                SEL_LCDC: result.read_data = ctrl_reg;
                SEL_STAT: result.read_data = {1'b1, stat_hi_reg[4:1], coincide, mode_show};
                SEL_SCY:  result.read_data = scy_reg;
                SEL_SCX:  result.read_data = scx_reg;
                SEL_LY:   result.read_data = ly_reg;
                SEL_LYC:  result.read_data = lyc_reg;
                SEL_BGP:  result.read_data = bgp_reg;
                SEL_OBP0: result.read_data = obp0_reg;
                SEL_OBP1: result.read_data = obp1_reg;
                SEL_WY:   result.read_data = wy_reg;
                SEL_WX:   result.read_data = wx_reg;
                default:  result.read_data = 8'd0;
            endcase
        end
        if (is_write)
        begin
            result.claimed = (sel != SEL_NONE);
        end
        if (is_tick && lcd_on && due)
        begin
            if (mode_reg == MODE_HBLANK)
            begin
                result.vblank_request = vbl_hit;
                result.stat_request   = (vbl_hit && en_vbl) || en_oam
                                        || (en_lyc && (lyc_reg == line_wrap));
            end
            if (mode_reg == MODE_VRAM)
            begin
                result.stat_request = en_hbl;
            end
        end
        result.current_mode = mode_next;
        result.current_line = ly_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= 8'd0;
            stat_hi_reg <= 6'd0;
            mode_reg    <= MODE_HBLANK;
            scy_reg     <= 8'd0;
            scx_reg     <= 8'd0;
            ly_reg      <= 8'd0;
            lyc_reg     <= 8'd0;
            bgp_reg     <= 8'd0;
            obp0_reg    <= 8'd0;
            obp1_reg    <= 8'd0;
            wy_reg      <= 8'd0;
            wx_reg      <= 8'd0;
            accum_reg   <= 16'd0;
        end
        else
        begin
            ctrl_reg    <= ctrl_next;
            stat_hi_reg <= stat_hi_next;
            mode_reg    <= mode_next;
            scy_reg     <= scy_next;
            scx_reg     <= scx_next;
            ly_reg      <= ly_next;
            lyc_reg     <= lyc_next;
            bgp_reg     <= bgp_next;
            obp0_reg    <= obp0_next;
            obp1_reg    <= obp1_next;
            wy_reg      <= wy_next;
            wx_reg      <= wx_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// ===== rtl/core/lcd_mode_timing_registers.sv =====
// lcd mode timing and register block: one result item for every input item
// an item is held in the input register, then its result in the result register
// throughput: one item per cycle while the result side is not stalled, set by the single
// pass through lmt_core between the input register and the result register
// reset: asynchronous, active low; valid bits, core registers, mode and line go to zero
module lcd_mode_timing_registers
    import lmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  lmt_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output lmt_out_t result
);

    logic     stage_valid_reg, stage_valid_next;
    lmt_in_t  stage_item_reg;
    logic     result_valid_reg, result_valid_next;
    lmt_out_t result_reg;
    lmt_out_t core_result;
    logic     advance;
    logic     step;

    // pipeline flow control
    assign advance    = !result_valid_reg || !result_stall;
    assign step       = stage_valid_reg && advance;
    assign item_stall = stage_valid_reg && !advance;

    assign stage_valid_next  = item_stall ? 1'b1 : item_valid;
    assign result_valid_next = advance ? step : 1'b1;

    // state and per-item logic
    lmt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_item_reg),
        .result (core_result)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!item_stall)
        begin
            stage_item_reg <= item;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // line counter stays inside the frame
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.current_line < LINES_PER_FRAME))
        else $error("line counter out of range");

    // vblank request only on entry to line 144 in oam mode
    a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.vblank_request) |->
        ((result.current_line == VBLANK_LINE) && (result.current_mode == MODE_OAM)))
        else $error("vblank request off line 144");

    // register accesses raise no interrupt request
    a_access_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.claimed) |->
        (!result.vblank_request && !result.stat_request))
        else $error("request raised on a register access");

    // the mode field never reports vblank
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.current_mode != MODE_VBLANK))
        else $error("vblank mode code in mode field");

    // a stalled input item stays in the input register
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> stage_valid_reg)
        else $error("input item dropped while stalled");

endmodule

// ===== test/tb_lcd_mode_timing_registers.sv =====
`timescale 1ns / 1ps

module tb_lcd_mode_timing_registers;
    import lmt_pkg::*;

    // the one kind code the block leaves unused
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // control and status bit positions
    localparam int LCDC_ON_BIT    = 7;
    localparam int STAT_COINC_BIT = 2;
    localparam int STAT_HBL_EN    = 3;
    localparam int STAT_VBL_EN    = 4;
    localparam int STAT_OAM_EN    = 5;
    localparam int STAT_LYC_EN    = 6;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;

    // one planned item: stimulus plus an optional hand-written expectation
    typedef struct packed {
        logic     typed;
        lmt_in_t  stim;
        lmt_out_t want;
    } item_plan_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    lmt_in_t  item = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    lmt_out_t result;

    // shadow copy of the block's registers
    logic [7:0]  lcdc_q = '0;
    logic [7:0]  stat_q = '0;
    logic [7:0]  scy_q = '0;
    logic [7:0]  scx_q = '0;
    logic [7:0]  ly_q = '0;
    logic [7:0]  lyc_q = '0;
    logic [7:0]  bgp_q = '0;
    logic [7:0]  obp0_q = '0;
    logic [7:0]  obp1_q = '0;
    logic [7:0]  wy_q = '0;
    logic [7:0]  wx_q = '0;
    logic [15:0] dot_accum_q = '0;

    item_plan_t directed_rows[$];
    item_plan_t pending_plans[$];
    lmt_out_t   expected_results[$];

    int errors = 0;
    int sent_count = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 86;
    logic hold_req = 1'b0;
    int n_ticks = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_vblank = 0;
    int n_stat = 0;
    int n_saturated = 0;

    lcd_mode_timing_registers DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lmt_in_t in_item(logic [1:0] k, logic [15:0] a, logic [7:0] d,
                                        logic [7:0] c);
        lmt_in_t x;
        x.kind = k;
        x.address = a;
        x.write_data = d;
        x.elapsed_cycles = c;
        return x;
    endfunction

    function automatic lmt_out_t out_item(logic [7:0] rd, logic cl, logic vb, logic st,
                                          mode_t md, logic [7:0] ln);
        lmt_out_t r;
        r.read_data = rd;
        r.claimed = cl;
        r.vblank_request = vb;
        r.stat_request = st;
        r.current_mode = md;
        r.current_line = ln;
        return r;
    endfunction

    task automatic add_row(logic typed, lmt_in_t stim, lmt_out_t want);
        item_plan_t p;
        p.typed = typed;
        p.stim = stim;
        p.want = want;
        directed_rows.push_back(p);
    endtask

    // advance the shadow registers by one item and return the result it causes
    function automatic lmt_out_t predict_lcd(lmt_in_t it);
        lmt_out_t r;
        logic [16:0] sum;
        logic [15:0] need;
        mode_t md;
        r = '0;
        need = '0;
        md = mode_t'(stat_q[1:0]);
        case (it.kind)
            KIND_TICK:
            begin
                if (!lcdc_q[LCDC_ON_BIT])
                begin
                    ly_q = '0;
                    stat_q[1:0] = MODE_HBLANK;
                end
                else
                begin
                    sum = {1'b0, dot_accum_q} + {9'd0, it.elapsed_cycles};
                    if (sum[16])
                        n_saturated++;
                    dot_accum_q = sum[16] ? 16'hffff : sum[15:0];
                    case (md)
                        MODE_HBLANK: need = {8'd0, HBLANK_CYCLES};
                        MODE_OAM:    need = {8'd0, OAM_CYCLES};
                        MODE_VRAM:   need = {8'd0, VRAM_CYCLES};
                        default:     need = '0;
                    endcase
                    // a mode move happens at most once per tick
                    if (md != MODE_VBLANK && dot_accum_q >= need)
                    begin
                        dot_accum_q = dot_accum_q - need;
                        case (md)
                            MODE_HBLANK:
                            begin
                                stat_q[1:0] = MODE_OAM;
                                ly_q = ly_q + 8'd1;
                                if (ly_q == VBLANK_LINE)
                                begin
                                    r.vblank_request = 1'b1;
                                    if (stat_q[STAT_VBL_EN])
                                        r.stat_request = 1'b1;
                                end
                                if (stat_q[STAT_OAM_EN])
                                    r.stat_request = 1'b1;
                                if (ly_q >= LINES_PER_FRAME)
                                    ly_q = '0;
                                if (stat_q[STAT_LYC_EN] && lyc_q == ly_q)
                                    r.stat_request = 1'b1;
                            end
                            MODE_OAM:
                                stat_q[1:0] = MODE_VRAM;
                            default:
                            begin
                                stat_q[1:0] = MODE_HBLANK;
                                if (stat_q[STAT_HBL_EN])
                                    r.stat_request = 1'b1;
                            end
                        endcase
                    end
                end
            end
            KIND_READ:
            begin
                r.claimed = 1'b1;
                case (it.address)
                    ADDR_LCDC: r.read_data = lcdc_q;
                    ADDR_STAT:
                    begin
                        stat_q[STAT_COINC_BIT] = (ly_q == lyc_q);
                        r.read_data = {1'b1, stat_q[6:2],
                                       ly_q >= VBLANK_LINE ? MODE_VBLANK : stat_q[1:0]};
                    end
                    ADDR_SCY:  r.read_data = scy_q;
                    ADDR_SCX:  r.read_data = scx_q;
                    ADDR_LY:   r.read_data = ly_q;
                    ADDR_LYC:  r.read_data = lyc_q;
                    ADDR_BGP:  r.read_data = bgp_q;
                    ADDR_OBP0: r.read_data = obp0_q;
                    ADDR_OBP1: r.read_data = obp1_q;
                    ADDR_WY:   r.read_data = wy_q;
                    ADDR_WX:   r.read_data = wx_q;
                    default:   r.claimed = 1'b0;
                endcase
            end
            KIND_WRITE:
            begin
                r.claimed = 1'b1;
                case (it.address)
                    ADDR_LCDC:
                    begin
                        // switching the display on restarts the frame
                        if (!lcdc_q[LCDC_ON_BIT] && it.write_data[LCDC_ON_BIT])
                        begin
                            ly_q = '0;
                            dot_accum_q = '0;
                            stat_q[1:0] = MODE_OAM;
                        end
                        lcdc_q = it.write_data;
                    end
                    ADDR_STAT: stat_q[7:2] = it.write_data[7:2];
                    ADDR_SCY:  scy_q = it.write_data;
                    ADDR_SCX:  scx_q = it.write_data;
                    ADDR_LY:   ;
                    ADDR_LYC:  lyc_q = it.write_data;
                    ADDR_DMA:  ;
                    ADDR_BGP:  bgp_q = it.write_data;
                    ADDR_OBP0: obp0_q = it.write_data;
                    ADDR_OBP1: obp1_q = it.write_data;
                    ADDR_WY:   wy_q = it.write_data;
                    ADDR_WX:   wx_q = it.write_data;
                    default:   r.claimed = 1'b0;
                endcase
            end
            default: ;
        endcase
        r.current_mode = stat_q[1:0];
        r.current_line = ly_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(lmt_in_t x, logic typed, lmt_out_t want);
        item_plan_t p;
        p.typed = typed;
        p.stim = x;
        p.want = want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        pending_plans.push_back(p);
        item_valid <= 1'b1;
        item <= x;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
        // idling phases: receiver sparse, then sender sparse, then no random gaps and one long hold
        if (sent_count == 400)
        begin
            send_idle_pct = 86;
            recv_idle_pct = 36;
        end
        if (sent_count == 800)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_req = 1'b1;
        end
    endtask

    // receiver stall, with one long hold-off once asked for
    initial
    begin : receiver
        logic hold_done;
        int stretch;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                for (stretch = 1; stretch < HOLD_CYCLES; stretch++)
                    @(posedge clk);
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // accepted item: predict its result
    always @(posedge clk)
    begin : take_item
        item_plan_t p;
        lmt_out_t guess;
        if (rst_n && item_valid && !item_stall)
        begin
            p = pending_plans.pop_front();
            guess = predict_lcd(item);
            expected_results.push_back(p.typed ? p.want : guess);
            case (item.kind)
                KIND_TICK:  n_ticks++;
                KIND_READ:  n_reads++;
                KIND_WRITE: n_writes++;
                default: ;
            endcase
        end
    end

    // accepted result: compare with the oldest expectation
    always @(posedge clk)
    begin : check_result
        lmt_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending: %h", result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_data", want.read_data, result.read_data);
                check_field("claimed", {7'd0, want.claimed}, {7'd0, result.claimed});
                check_field("vblank_request", {7'd0, want.vblank_request},
                            {7'd0, result.vblank_request});
                check_field("stat_request", {7'd0, want.stat_request},
                            {7'd0, result.stat_request});
                check_field("current_mode", {6'd0, want.current_mode},
                            {6'd0, result.current_mode});
                check_field("current_line", want.current_line, result.current_line);
                if (result.vblank_request)
                    n_vblank++;
                if (result.stat_request)
                    n_stat++;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $error("no handshake for %0d cycles", quiet);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        lmt_in_t x;
        int n;
        int pick;

        // directed rows, display off first, then a short enabled run
        add_row(1, in_item(KIND_READ, ADDR_LCDC, 8'h00, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_STAT, 8'h00, 8'h00),
                out_item(8'h84, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_DMA, 8'hff, 8'hff),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_LCDC - 16'd1, 8'h00, 8'h00),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_WX + 16'd1, 8'h00, 8'h00),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_TICK, 16'hffff, 8'hff, 8'hff),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_SPARE, ADDR_LCDC, 8'hff, 8'hff),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_LCDC - 16'd1, 8'hff, 8'h00),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_LY, 8'hff, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_DMA, 8'hff, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_WX, 8'hff, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_WX, 8'h00, 8'h00),
                out_item(8'hff, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_STAT, 8'hff, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_LYC, 8'h01, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_LCDC, 8'h80, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_OAM, 8'd0));
        add_row(1, in_item(KIND_TICK, 16'h0000, 8'h00, 8'h00),
                out_item(8'h00, 0, 0, 0, MODE_OAM, 8'd0));
        add_row(1, in_item(KIND_TICK, 16'h0000, 8'h00, 8'd80),
                out_item(8'h00, 0, 0, 0, MODE_VRAM, 8'd0));
        add_row(0, in_item(KIND_TICK, 16'h0000, 8'h00, 8'hff), '0);
        add_row(0, in_item(KIND_TICK, 16'h0000, 8'h00, 8'hff), '0);
        add_row(0, in_item(KIND_READ, ADDR_STAT, 8'h00, 8'h00), '0);
        add_row(0, in_item(KIND_READ, ADDR_LY, 8'h00, 8'h00), '0);
        add_row(0, in_item(KIND_WRITE, ADDR_LCDC, 8'h00, 8'h00), '0);
        add_row(1, in_item(KIND_TICK, 16'h0000, 8'h00, 8'd10),
                out_item(8'h00, 0, 0, 0, MODE_HBLANK, 8'd0));
        add_row(1, in_item(KIND_WRITE, ADDR_LCDC, 8'hff, 8'h00),
                out_item(8'h00, 1, 0, 0, MODE_OAM, 8'd0));
        add_row(1, in_item(KIND_READ, ADDR_LCDC, 8'h00, 8'h00),
                out_item(8'hff, 1, 0, 0, MODE_OAM, 8'd0));

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // restart the frame with random stat enables and compare line
        send_item(in_item(KIND_WRITE, ADDR_LCDC, 8'h00, 8'h00), 0, '0);
        send_item(in_item(KIND_WRITE, ADDR_STAT, 8'($urandom), 8'h00), 0, '0);
        send_item(in_item(KIND_WRITE, ADDR_LYC, 8'($urandom_range(153)), 8'h00), 0, '0);
        send_item(in_item(KIND_WRITE, ADDR_LCDC, 8'h80 | 8'($urandom), 8'h00), 0, '0);

        // long enabled run: heavy ticks walk through full frames and
        // eventually drive the cycle accumulator into saturation
        for (n = 0; n < 900; n++)
        begin
            x = in_item(KIND_TICK, 16'($urandom), 8'($urandom),
                        $urandom_range(15) == 0 ? 8'($urandom) : 8'hff);
            if ($urandom_range(9) == 0)
            begin
                pick = $urandom_range(4);
                case (pick)
                    0: x = in_item(KIND_READ, ADDR_STAT, 8'($urandom), 8'($urandom));
                    1: x = in_item(KIND_READ, ADDR_LY, 8'($urandom), 8'($urandom));
                    2: x = in_item(KIND_READ, ADDR_LCDC + 16'($urandom_range(11)),
                                   8'($urandom), 8'($urandom));
                    3: x = in_item(KIND_WRITE, ADDR_LYC, 8'($urandom_range(153)),
                                   8'($urandom));
                    default: x = in_item(KIND_WRITE, ADDR_STAT, 8'($urandom), 8'($urandom));
                endcase
            end
            send_item(x, 0, '0);
        end

        // random mix of all kinds, mostly inside the register window
        for (n = 0; n < 250; n++)
        begin
            pick = $urandom_range(99);
            x.kind = pick < 40 ? KIND_TICK : pick < 65 ? KIND_READ :
                     pick < 95 ? KIND_WRITE : KIND_SPARE;
            x.address = $urandom_range(4) == 0 ? 16'($urandom)
                                                : ADDR_LCDC + 16'($urandom_range(11));
            x.write_data = 8'($urandom);
            x.elapsed_cycles = 8'($urandom);
            send_item(x, 0, '0);
        end

        // drain
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items: %0d ticks, %0d reads, %0d writes",
                 sent_count, n_ticks, n_reads, n_writes);
        $display("saw %0d vblank and %0d stat pulses, %0d accumulator saturations",
                 n_vblank, n_stat, n_saturated);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
